// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Depends on nothing; take in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true implies consequent true in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Antecedent true implies consequent true in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ----- hw/rtl/cvq_pkg.sv -----
// Package for the compacting verdict queue: sizes, codes, command and state types.
// Depends on nothing; the files that use it refer to it by scoped names.
package cvq_pkg;

    localparam int NUM_QUEUES  = 4;
    localparam int QUEUE_DEPTH = 64;
    localparam int NUM_REGS    = 4;

    localparam int Q_W        = 2;
    localparam int WORD_W     = 32;
    localparam int TIME_W     = 31;
    localparam int RD_POS_W   = 6;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int LEN_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CELLS      = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W     = Q_W + PTR_W;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int LEN_RESET = 64;
    localparam logic [WORD_W-1:0] EMPTY_CELL = '1;

    typedef enum logic
    {
        OP_WRITE,
        OP_CHECK
    } op_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_WR_CUR,
        ST_WR_PREV,
        ST_WR_EXEC,
        ST_CK_START,
        ST_CK_SCAN,
        ST_CK_OUT
    } state_t;

    typedef logic [NUM_REGS-1:0][CFG_W-1:0] cfg_len_t;

    // Classified command handed from the front to the back.
    typedef struct packed
    {
        op_t               op;
        logic [Q_W-1:0]    q;
        logic [WORD_W-1:0] value;
        logic [TIME_W-1:0] wanted;
        logic [PTR_W-1:0]  rd;
        logic [PTR_W-1:0]  last;
        logic [LEN_W-1:0]  len;
    } cmd_t;

endpackage

// ----- hw/rtl/cvq_in_if.sv -----
// Input channel of the verdict queue: valid, ready and the item fields.
// Depends on nothing.
interface cvq_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [1:0]  queue_select;
    logic [31:0] verdict_in;
    logic [5:0]  read_position;
    logic [30:0] wanted_time;

    modport source
    (
        output valid, action, queue_select, verdict_in, read_position, wanted_time,
        input  ready
    );

    modport sink
    (
        input  valid, action, queue_select, verdict_in, read_position, wanted_time,
        output ready
    );
endinterface

// ----- hw/rtl/cvq_out_if.sv -----
// Result channel of the verdict queue: valid, ready and the result fields.
// Depends on nothing.
interface cvq_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] verdict_out;
    logic [5:0]  new_read_position;

    modport source
    (
        output valid, found, verdict_out, new_read_position,
        input  ready
    );

    modport sink
    (
        input  valid, found, verdict_out, new_read_position,
        output ready
    );
endinterface

// ----- hw/rtl/compacting_verdict_queue.sv -----
// Top level of the compacting verdict queue: length registers, front end and back end.
// Depends on cvq_pkg, cvq_in_if, cvq_out_if, cvq_front and cvq_back.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    action, queue_select, verdict_in, read_position,
//                                  wanted_time
//   out_ch    out   valid/ready    found, verdict_out, new_read_position
//   cfg       in    cfg_we         cfg_index, cfg_data
//
// A write in the back end runs dequeue, read current cell, read previous cell, store.
// A check runs dequeue, first read, a scan of 1 up to the queue length cells (one a cycle
// through the single read port), load of the output.
// Reset clears per-cell valid bits at once; there is no clearing pass.
// The front queue holds two transactions, so input is taken while the back end works
// and while a result waits in the output register; a full output register holds the
// back end.
module compacting_verdict_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    cvq_in_if.sink                          in_ch,
    cvq_out_if.source                       out_ch,
    input  logic                            cfg_we,
    input  logic [cvq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cvq_pkg::CFG_W-1:0]       cfg_data
);

    cvq_pkg::cfg_len_t length_reg;
    logic              cmd_valid;
    cvq_pkg::cmd_t     cmd;
    logic              cmd_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cvq_pkg::NUM_REGS; i++)
            begin
                length_reg[i] <= cvq_pkg::CFG_W'(cvq_pkg::LEN_RESET);
            end
        end
        else if (cfg_we)
        begin
            length_reg[cfg_index] <= cfg_data;
        end
    end

    cvq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg_len   (length_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    cvq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_ch    (out_ch)
    );

endmodule

// ----- hw/rtl/cvq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module cvq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/cvq_front.sv -----
// Front end: accepts input transactions, classifies them and holds them in a short queue.
// Depends on cvq_pkg and cvq_in_if.
module cvq_front (
    input  logic              clk,
    input  logic              rst_n,
    cvq_in_if.sink            in_ch,
    input  cvq_pkg::cfg_len_t cfg_len,
    output logic              cmd_valid,
    output cvq_pkg::cmd_t     cmd,
    input  logic              cmd_pop
);

    cvq_pkg::cmd_t                   fifo_mem [cvq_pkg::FIFO_DEPTH];
    logic [cvq_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [cvq_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [cvq_pkg::FIFO_CNT_W-1:0] count_reg;
    cvq_pkg::cmd_t                   cls;
    logic                            push;
    int unsigned                     raw_len;
    int unsigned                     act_len;
    int unsigned                     rd_u;

    // Clamp the length and clip the read pointer once, on the way in.
    always_comb
    begin
        raw_len = int'(cfg_len[in_ch.queue_select]);
        if (raw_len == 0)
        begin
            act_len = 1;
        end
        else if (raw_len > cvq_pkg::QUEUE_DEPTH)
        begin
            act_len = cvq_pkg::QUEUE_DEPTH;
        end
        else
        begin
            act_len = raw_len;
        end
        rd_u = int'(in_ch.read_position);

        cls.op     = in_ch.action ? cvq_pkg::OP_CHECK : cvq_pkg::OP_WRITE;
        cls.q      = in_ch.queue_select;
        cls.value  = in_ch.verdict_in;
        cls.wanted = in_ch.wanted_time;
        cls.len    = cvq_pkg::LEN_W'(act_len);
        cls.last   = cvq_pkg::PTR_W'(act_len - 1);
        cls.rd     = (rd_u >= act_len) ? '0 : cvq_pkg::PTR_W'(rd_u);
    end

    assign in_ch.ready = (count_reg != cvq_pkg::FIFO_CNT_W'(cvq_pkg::FIFO_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign cmd_valid   = (count_reg != '0);
    assign cmd         = fifo_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + cvq_pkg::FIFO_PTR_W'(1);
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + cvq_pkg::FIFO_PTR_W'(1);
            end
            if (push && !cmd_pop)
            begin
                count_reg <= count_reg + cvq_pkg::FIFO_CNT_W'(1);
            end
            else if (!push && cmd_pop)
            begin
                count_reg <= count_reg - cvq_pkg::FIFO_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ----- hw/rtl/cvq_back.sv -----
// Back end: carries out writes with compaction and forward scans over the cell store.
// Depends on cvq_pkg, cvq_out_if and cvq_ram.
module cvq_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  cvq_pkg::cmd_t cmd,
    output logic          cmd_pop,
    cvq_out_if.source     out_ch
);

    cvq_pkg::state_t             state_reg;
    cvq_pkg::state_t             state_next;
    cvq_pkg::cmd_t               cmd_reg;
    logic [cvq_pkg::PTR_W-1:0]   wpos_reg [cvq_pkg::NUM_QUEUES];
    logic                        valid_reg [cvq_pkg::CELLS];
    logic                        rvalid_reg;
    logic [cvq_pkg::PTR_W-1:0]   wp_reg;
    logic [cvq_pkg::PTR_W-1:0]   prev_reg;
    logic [cvq_pkg::WORD_W-1:0]  cur_reg;
    logic [cvq_pkg::PTR_W-1:0]   rd_reg;
    logic [cvq_pkg::LEN_W-1:0]   cnt_reg;
    logic                        res_found_reg;
    logic [cvq_pkg::WORD_W-1:0]  res_word_reg;
    logic [cvq_pkg::PTR_W-1:0]   res_pos_reg;
    logic                        out_valid_reg;
    logic                        out_found_reg;
    logic [cvq_pkg::WORD_W-1:0]  out_word_reg;
    logic [cvq_pkg::PTR_W-1:0]   out_pos_reg;

    logic                        ram_we;
    logic [cvq_pkg::ADDR_W-1:0]  ram_waddr;
    logic                        ram_re;
    logic [cvq_pkg::ADDR_W-1:0]  ram_raddr;
    logic [cvq_pkg::WORD_W-1:0]  ram_rdata;

    logic [cvq_pkg::PTR_W-1:0]   wp_stored;
    logic [cvq_pkg::PTR_W-1:0]   wp_clip;
    logic [cvq_pkg::PTR_W-1:0]   wp_prev;
    logic [cvq_pkg::WORD_W-1:0]  cell_word;
    logic                        compact;
    logic [cvq_pkg::PTR_W-1:0]   target;
    logic [cvq_pkg::PTR_W-1:0]   target_next;
    logic                        hit;
    logic                        empty_start;
    logic [cvq_pkg::PTR_W-1:0]   rd_next;
    logic [cvq_pkg::LEN_W-1:0]   cnt_next;
    logic                        scan_done;
    logic                        out_free;
    logic                        load_out;

    cvq_ram #(
        .WIDTH (cvq_pkg::WORD_W),
        .DEPTH (cvq_pkg::CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd_reg.value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Datapath decisions
    always_comb
    begin
        wp_stored   = wpos_reg[cmd_reg.q];
        wp_clip     = ({1'b0, wp_stored} >= {{(cvq_pkg::LEN_W - cvq_pkg::PTR_W){1'b0}},
                       cmd_reg.len[cvq_pkg::PTR_W-1:0]} && cmd_reg.len != '0 &&
                       {1'b0, wp_stored} >= cmd_reg.len) ? '0 : wp_stored;
        wp_prev     = (wp_clip == '0) ? cmd_reg.last : wp_clip - cvq_pkg::PTR_W'(1);
        // A cell never written reads as the empty marker.
        cell_word   = rvalid_reg ? ram_rdata : cvq_pkg::EMPTY_CELL;
        compact     = (cell_word[cvq_pkg::WORD_W-1] == cmd_reg.value[cvq_pkg::WORD_W-1]) &&
                      (cell_word != cur_reg) && (cur_reg != cvq_pkg::EMPTY_CELL);
        target      = compact ? prev_reg : wp_reg;
        target_next = (target == cmd_reg.last) ? '0 : target + cvq_pkg::PTR_W'(1);
        hit         = (cell_word[cvq_pkg::TIME_W-1:0] >= cmd_reg.wanted);
        empty_start = (cnt_reg == '0) && (cell_word == cvq_pkg::EMPTY_CELL);
        rd_next     = (rd_reg == cmd_reg.last) ? '0 : rd_reg + cvq_pkg::PTR_W'(1);
        cnt_next    = cnt_reg + cvq_pkg::LEN_W'(1);
        scan_done   = empty_start || hit || (rd_next == wp_reg) || (cnt_next == cmd_reg.len);
        out_free    = !out_valid_reg || out_ch.ready;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cvq_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = (cmd.op == cvq_pkg::OP_WRITE) ? cvq_pkg::ST_WR_CUR
                                                               : cvq_pkg::ST_CK_START;
                end
            end
            cvq_pkg::ST_WR_CUR:   state_next = cvq_pkg::ST_WR_PREV;
            cvq_pkg::ST_WR_PREV:  state_next = cvq_pkg::ST_WR_EXEC;
            cvq_pkg::ST_WR_EXEC:  state_next = cvq_pkg::ST_IDLE;
            cvq_pkg::ST_CK_START: state_next = cvq_pkg::ST_CK_SCAN;
            cvq_pkg::ST_CK_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = cvq_pkg::ST_CK_OUT;
                end
            end
            cvq_pkg::ST_CK_OUT:
            begin
                if (out_free)
                begin
                    state_next = cvq_pkg::ST_IDLE;
                end
            end
            default: state_next = cvq_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        cmd_pop   = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = {cmd_reg.q, wp_clip};
        ram_we    = 1'b0;
        ram_waddr = {cmd_reg.q, target};
        load_out  = 1'b0;
        case (state_reg)
            cvq_pkg::ST_IDLE:
            begin
                cmd_pop = cmd_valid;
            end
            cvq_pkg::ST_WR_CUR:
            begin
                ram_re    = 1'b1;
                ram_raddr = {cmd_reg.q, wp_clip};
            end
            cvq_pkg::ST_WR_PREV:
            begin
                ram_re    = 1'b1;
                ram_raddr = {cmd_reg.q, prev_reg};
            end
            cvq_pkg::ST_WR_EXEC:
            begin
                ram_we = 1'b1;
            end
            cvq_pkg::ST_CK_START:
            begin
                ram_re    = 1'b1;
                ram_raddr = {cmd_reg.q, cmd_reg.rd};
            end
            cvq_pkg::ST_CK_SCAN:
            begin
                ram_re    = !scan_done;
                ram_raddr = {cmd_reg.q, rd_next};
            end
            cvq_pkg::ST_CK_OUT:
            begin
                load_out = out_free;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cvq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            rvalid_reg    <= 1'b0;
            for (int i = 0; i < cvq_pkg::NUM_QUEUES; i++)
            begin
                wpos_reg[i] <= '0;
            end
            for (int i = 0; i < cvq_pkg::CELLS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ram_re)
            begin
                rvalid_reg <= valid_reg[ram_raddr];
            end
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
                wpos_reg[cmd_reg.q]  <= target_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
        case (state_reg)
            cvq_pkg::ST_WR_CUR:
            begin
                wp_reg   <= wp_clip;
                prev_reg <= wp_prev;
            end
            cvq_pkg::ST_WR_PREV:
            begin
                cur_reg <= cell_word;
            end
            cvq_pkg::ST_CK_START:
            begin
                wp_reg  <= wp_clip;
                rd_reg  <= cmd_reg.rd;
                cnt_reg <= '0;
            end
            cvq_pkg::ST_CK_SCAN:
            begin
                if (scan_done)
                begin
                    // Running out of cells leaves the pointer on the last one examined.
                    res_found_reg <= hit && !empty_start;
                    res_word_reg  <= (hit && !empty_start) ? cell_word : '0;
                    res_pos_reg   <= rd_reg;
                end
                else
                begin
                    rd_reg  <= rd_next;
                    cnt_reg <= cnt_next;
                end
            end
            default:
            begin
                cur_reg <= cur_reg;
            end
        endcase
        if (load_out)
        begin
            out_found_reg <= res_found_reg;
            out_word_reg  <= res_word_reg;
            out_pos_reg   <= res_pos_reg;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.found             = out_found_reg;
    assign out_ch.verdict_out       = out_word_reg;
    assign out_ch.new_read_position = cvq_pkg::RD_POS_W'(out_pos_reg);

endmodule

// ----- hw/rtl/cvq_checker.sv -----
// Port-level checker for the compacting verdict queue, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module cvq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_action,
    input logic        out_valid,
    input logic        out_ready,
    input logic        found,
    input logic [31:0] verdict_out,
    input logic [5:0]  new_read_position
);

    logic [2:0] pending_reg;
    logic       chk_in;
    logic       res_out;

    assign chk_in  = in_valid && in_ready && in_action;
    assign res_out = out_valid && out_ready;

    // Count checks accepted but not yet answered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (chk_in && !res_out)
        begin
            pending_reg <= pending_reg + 3'd1;
        end
        else if (!chk_in && res_out)
        begin
            pending_reg <= pending_reg - 3'd1;
        end
    end

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(found) && $stable(verdict_out) && $stable(new_read_position))
    `ASSERT_SAME(a_result_has_check, clk, rst_n, out_valid, pending_reg != 3'd0)
    `ASSERT_SAME(a_miss_zero_word, clk, rst_n, out_valid && !found, verdict_out == 32'd0)

endmodule

bind compacting_verdict_queue cvq_checker u_cvq_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_action         (in_ch.action),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .found             (out_ch.found),
    .verdict_out       (out_ch.verdict_out),
    .new_read_position (out_ch.new_read_position)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for compacting_verdict_queue: random and directed writes and checks,
// scored against an in-bench model of the cells and write pointers.
// Depends on cvq_pkg, cvq_in_if, cvq_out_if and the RTL of the block.
module tb_top;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 7;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam logic [cvq_pkg::TIME_W-1:0] MAX_TIME = '1;

    typedef enum logic [cvq_pkg::CFG_IDX_W-1:0]
    {
        REG_LENGTH_QUEUE0,
        REG_LENGTH_QUEUE1,
        REG_LENGTH_QUEUE2,
        REG_LENGTH_QUEUE3
    } length_reg_t;

    typedef struct packed
    {
        cvq_pkg::op_t                action;
        logic [cvq_pkg::Q_W-1:0]     queue_select;
        logic [cvq_pkg::WORD_W-1:0]  verdict;
        logic [5:0]                  read_pos;
        logic [cvq_pkg::TIME_W-1:0]  wanted;
    } verdict_job_t;

    typedef struct packed
    {
        logic                        found;
        logic [cvq_pkg::WORD_W-1:0]  verdict;
        logic [5:0]                  read_pos;
    } lookup_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [cvq_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cvq_pkg::CFG_W-1:0] cfg_data;

    cvq_in_if  in_ch ();
    cvq_out_if out_ch ();

    compacting_verdict_queue DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Model state
    logic [cvq_pkg::WORD_W-1:0] cells [cvq_pkg::NUM_QUEUES][cvq_pkg::QUEUE_DEPTH];
    int                         write_ptr [cvq_pkg::NUM_QUEUES];
    logic [cvq_pkg::CFG_W-1:0]  queue_len [cvq_pkg::NUM_QUEUES];

    verdict_job_t   pending_jobs [$];
    lookup_result_t expected_lookups [$];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_requests;
    int  hold_served;
    int  hold_left;
    int  error_count;
    int  cycle_count;
    logic in_taken;

    logic [cvq_pkg::TIME_W-1:0] stamp [cvq_pkg::NUM_QUEUES];
    logic                       last_truth [cvq_pkg::NUM_QUEUES];

    function automatic int effective_len(input logic [cvq_pkg::Q_W-1:0] q);
        int len;
        len = int'(queue_len[q]);
        if (len == 0)
            len = 1;
        if (len > cvq_pkg::QUEUE_DEPTH)
            len = cvq_pkg::QUEUE_DEPTH;
        return len;
    endfunction

    function automatic void store_verdict(input logic [cvq_pkg::Q_W-1:0] q,
                                          input logic [cvq_pkg::WORD_W-1:0] value);
        int len;
        int wp;
        int prev;
        len = effective_len(q);
        wp = (write_ptr[q] >= len) ? 0 : write_ptr[q];
        prev = (wp == 0) ? len - 1 : wp - 1;
        // compact onto the previous cell
        if (cells[q][prev][cvq_pkg::WORD_W-1] == value[cvq_pkg::WORD_W-1]
            && cells[q][prev] != cells[q][wp] && cells[q][wp] != cvq_pkg::EMPTY_CELL)
            wp = prev;
        cells[q][wp] = value;
        write_ptr[q] = (wp + 1 >= len) ? 0 : wp + 1;
    endfunction

    function automatic lookup_result_t scan_for_verdict(
        input logic [cvq_pkg::Q_W-1:0] q,
        input logic [5:0] rd_in,
        input logic [cvq_pkg::TIME_W-1:0] wanted);
        lookup_result_t res;
        int len;
        int wp;
        int rd;
        logic [cvq_pkg::WORD_W-1:0] c;
        res.found = 1'b0;
        res.verdict = '0;
        res.read_pos = rd_in;
        len = effective_len(q);
        wp = (write_ptr[q] >= len) ? 0 : write_ptr[q];
        rd = (int'(rd_in) >= len) ? 0 : int'(rd_in);
        if (cells[q][rd] == cvq_pkg::EMPTY_CELL)
        begin
            res.read_pos = rd[5:0];
            return res;
        end
        for (int n = 0; n < len; n++)
        begin
            c = cells[q][rd];
            if (c[cvq_pkg::TIME_W-1:0] >= wanted)
            begin
                res.found = 1'b1;
                res.verdict = c;
                res.read_pos = rd[5:0];
                return res;
            end
            rd = (rd + 1 >= len) ? 0 : rd + 1;
            if (rd == wp)
                break;
        end
        // ran into the write pointer or out of cells: step back one
        rd = (rd == 0) ? len - 1 : rd - 1;
        res.read_pos = rd[5:0];
        return res;
    endfunction

    task automatic add_job(input cvq_pkg::op_t action, input logic [cvq_pkg::Q_W-1:0] q,
                           input logic [cvq_pkg::WORD_W-1:0] verdict, input logic [5:0] rd,
                           input logic [cvq_pkg::TIME_W-1:0] wanted);
        verdict_job_t job;
        job.action = action;
        job.queue_select = q;
        job.verdict = verdict;
        job.read_pos = rd;
        job.wanted = wanted;
        pending_jobs.push_back(job);
    endtask

    // Mostly well-formed traffic: non-decreasing times per queue, repeated truth to provoke
    // compaction, checks aimed near the latest time; a little pure noise.
    function automatic verdict_job_t random_job();
        verdict_job_t job;
        int r;
        int pick;
        logic [cvq_pkg::Q_W-1:0] q;
        logic [cvq_pkg::TIME_W-1:0] delta;
        r = $urandom_range(99);
        q = cvq_pkg::Q_W'($urandom_range(cvq_pkg::NUM_QUEUES - 1));
        job.queue_select = q;
        job.verdict = $urandom;
        job.read_pos = 6'($urandom_range(63));
        job.wanted = cvq_pkg::TIME_W'($urandom);
        if (r < 8)
        begin
            job.action = cvq_pkg::op_t'($urandom_range(1));
        end
        else if (r < 58)
        begin
            job.action = cvq_pkg::OP_WRITE;
            stamp[q] = stamp[q] + cvq_pkg::TIME_W'($urandom_range(3));
            if ($urandom_range(99) >= 70)
                last_truth[q] = ~last_truth[q];
            job.verdict = {last_truth[q], stamp[q]};
        end
        else
        begin
            job.action = cvq_pkg::OP_CHECK;
            if ($urandom_range(99) < 75)
                job.read_pos = 6'($urandom_range(effective_len(q) - 1));
            pick = $urandom_range(99);
            delta = cvq_pkg::TIME_W'($urandom_range(8));
            if (pick < 50)
                job.wanted = (stamp[q] > delta) ? stamp[q] - delta : '0;
            else if (pick < 70)
                job.wanted = '0;
            else if (pick < 80)
                job.wanted = MAX_TIME;
            else
                job.wanted = stamp[q] + delta + cvq_pkg::TIME_W'(1);
        end
        return job;
    endfunction

    task automatic wait_until_settled();
        while (pending_jobs.size() != 0 || in_ch.valid || expected_lookups.size() != 0)
            @(posedge clk);
        // a trailing write may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input length_reg_t idx,
                                input logic [cvq_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        queue_len[idx] = value;
    endtask

    task automatic set_lengths(input logic [cvq_pkg::CFG_W-1:0] l0,
                               input logic [cvq_pkg::CFG_W-1:0] l1,
                               input logic [cvq_pkg::CFG_W-1:0] l2,
                               input logic [cvq_pkg::CFG_W-1:0] l3);
        write_length(REG_LENGTH_QUEUE0, l0);
        write_length(REG_LENGTH_QUEUE1, l1);
        write_length(REG_LENGTH_QUEUE2, l2);
        write_length(REG_LENGTH_QUEUE3, l3);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int send_pct, input int stall_pct, input int count);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            pending_jobs.push_back(random_job());
        wait_until_settled();
    endtask

    function automatic logic [cvq_pkg::CFG_W-1:0] random_length();
        if ($urandom_range(3) == 0)
            return cvq_pkg::CFG_W'($urandom_range(127));
        return cvq_pkg::CFG_W'($urandom_range(1, 10));
    endfunction

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.action = 1'b0;
        in_ch.queue_select = '0;
        in_ch.verdict_in = '0;
        in_ch.read_position = '0;
        in_ch.wanted_time = '0;
        out_ch.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests = 0;
        hold_served = 0;
        hold_left = 0;
        error_count = 0;
        cycle_count = 0;
        in_taken = 1'b0;
        for (int q = 0; q < cvq_pkg::NUM_QUEUES; q++)
        begin
            write_ptr[q] = 0;
            queue_len[q] = cvq_pkg::CFG_W'(cvq_pkg::LEN_RESET);
            stamp[q] = cvq_pkg::TIME_W'(100);
            last_truth[q] = 1'b0;
            for (int c = 0; c < cvq_pkg::QUEUE_DEPTH; c++)
                cells[q][c] = cvq_pkg::EMPTY_CELL;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty queues, plain scans, extreme words at full length
        add_job(cvq_pkg::OP_CHECK, 2'd0, '0, 6'd0, '0);
        add_job(cvq_pkg::OP_CHECK, 2'd1, '0, 6'd63, MAX_TIME);
        add_job(cvq_pkg::OP_WRITE, 2'd0, {1'b1, 31'd10}, 6'd0, '0);
        add_job(cvq_pkg::OP_WRITE, 2'd0, {1'b1, 31'd20}, 6'd0, '0);
        add_job(cvq_pkg::OP_WRITE, 2'd0, {1'b0, 31'd30}, 6'd0, '0);
        add_job(cvq_pkg::OP_CHECK, 2'd0, '0, 6'd0, '0);
        add_job(cvq_pkg::OP_CHECK, 2'd0, '0, 6'd0, 31'd25);
        add_job(cvq_pkg::OP_CHECK, 2'd0, '0, 6'd0, MAX_TIME);
        add_job(cvq_pkg::OP_CHECK, 2'd0, '0, 6'd5, '0);
        add_job(cvq_pkg::OP_WRITE, 2'd1, {1'b0, MAX_TIME}, 6'd0, '0);
        add_job(cvq_pkg::OP_WRITE, 2'd1, {1'b1, 31'd0}, 6'd0, '0);
        add_job(cvq_pkg::OP_WRITE, 2'd1, cvq_pkg::EMPTY_CELL, 6'd0, '0);
        add_job(cvq_pkg::OP_CHECK, 2'd1, '0, 6'd0, MAX_TIME);
        add_job(cvq_pkg::OP_CHECK, 2'd1, '0, 6'd1, 31'd1);
        add_job(cvq_pkg::OP_CHECK, 2'd1, '0, 6'd63, '0);
        wait_until_settled();

        // shortened lengths: clipped pointers, compaction, length of one
        set_lengths(7'd3, 7'd1, 7'd64, 7'd64);
        add_job(cvq_pkg::OP_WRITE, 2'd0, {1'b1, 31'd40}, 6'd0, '0);
        add_job(cvq_pkg::OP_WRITE, 2'd0, {1'b1, 31'd50}, 6'd0, '0);
        add_job(cvq_pkg::OP_CHECK, 2'd0, '0, 6'd1, 31'd45);
        add_job(cvq_pkg::OP_WRITE, 2'd1, {1'b1, 31'd1}, 6'd0, '0);
        add_job(cvq_pkg::OP_WRITE, 2'd1, {1'b1, 31'd2}, 6'd0, '0);
        add_job(cvq_pkg::OP_CHECK, 2'd1, '0, 6'd5, '0);
        add_job(cvq_pkg::OP_CHECK, 2'd1, '0, 6'd0, 31'd3);
        wait_until_settled();

        set_lengths(7'd4, 7'd1, 7'd2, 7'd64);
        run_phase(0, 0, 250);
        set_lengths(7'd0, 7'd65, 7'd127, 7'd3);
        run_phase(78, 0, 250);
        set_lengths(7'd8, 7'd16, 7'd5, 7'd2);
        run_phase(0, 78, 250);
        set_lengths(7'd64, 7'd64, 7'd64, 7'd64);
        run_phase(22, 22, 250);

        // hold the result side while input keeps coming, so the block backs up
        set_lengths(7'd6, 7'd6, 7'd6, 7'd6);
        hold_requests = hold_requests + 1;
        run_phase(0, 0, 100);

        for (int p = 0; p < 3; p++)
        begin
            set_lengths(random_length(), random_length(), random_length(), random_length());
            case (p)
                0: run_phase(22, 22, 250);
                1: run_phase(78, 0, 250);
                default: run_phase(0, 78, 250);
            endcase
        end

        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Input driver
    always @(negedge clk)
    begin
        verdict_job_t job;
        if (rst_n && (!in_ch.valid || in_taken))
        begin
            if (pending_jobs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                job = pending_jobs.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.action <= job.action;
                in_ch.queue_select <= job.queue_select;
                in_ch.verdict_in <= job.verdict;
                in_ch.read_position <= job.read_pos;
                in_ch.wanted_time <= job.wanted;
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result side ready, with an occasional long hold
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Apply each accepted transaction to the model
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            if (cvq_pkg::op_t'(in_ch.action) == cvq_pkg::OP_WRITE)
                store_verdict(in_ch.queue_select, in_ch.verdict_in);
            else
                expected_lookups.push_back(scan_for_verdict(in_ch.queue_select,
                                                            in_ch.read_position,
                                                            in_ch.wanted_time));
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_lookups.size() == 0)
            begin
                $display("%0t: unexpected result found=%0b verdict=%h pos=%0d", $time,
                         out_ch.found, out_ch.verdict_out, out_ch.new_read_position);
                error_count = error_count + 1;
            end
            else
            begin
                want = expected_lookups.pop_front();
                if (out_ch.found !== want.found)
                begin
                    $display("%0t: found expected %0b actual %0b", $time, want.found,
                             out_ch.found);
                    error_count = error_count + 1;
                end
                if (out_ch.verdict_out !== want.verdict)
                begin
                    $display("%0t: verdict_out expected %h actual %h", $time, want.verdict,
                             out_ch.verdict_out);
                    error_count = error_count + 1;
                end
                if (out_ch.new_read_position !== want.read_pos)
                begin
                    $display("%0t: new_read_position expected %0d actual %0d", $time,
                             want.read_pos, out_ch.new_read_position);
                    error_count = error_count + 1;
                end
            end
        end
    end

endmodule
